// ===== design/sfla_pkg.sv =====
// Package for the slab free list allocator: request and response types,
// operation, status, configuration register and controller state codes.
// No dependencies; every other design file imports it.
package sfla_pkg;

  // Operation codes carried by a request
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Status codes carried by a response
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_OUT_OF_MEM = 3'd1,
    STATUS_RANGE     = 3'd2,
    STATUS_MISALIGN  = 3'd3,
    STATUS_DOUBLE    = 3'd4,
    STATUS_CORRUPT   = 3'd5
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_SLAB_BYTES   = 2'd1,
    CFG_SLAB_COUNT   = 2'd2,
    CFG_CHECK_ENABLE = 2'd3
  } cfg_index_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_ALLOC_CHK,
    ST_FREE_RANGE,
    ST_FREE_DIV,
    ST_FREE_CHK,
    ST_DONE
  } state_t;

  // Field widths, divider steps and slab size bounds fixed by the interface
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 17;
  localparam int COUNT_W     = 11;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = 6;
  localparam logic [SIZE_W-1:0] SIZE_MIN = 17'd4;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 17'd65536;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] free_address;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] slab_address;
    status_t           status;
  } out_rsp_t;

  // Divider result as seen by the controller
  typedef struct packed {
    logic              done;
    logic              rem_zero;
    logic [ADDR_W-1:0] quotient;
  } div_result_t;

endpackage

// ===== design/sfla_divider.sv =====
// Iterative restoring divider: 32-bit byte offset by a 17-bit slab size,
// one quotient bit per cycle. Depends on sfla_pkg.
module sfla_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sfla_pkg::ADDR_W-1:0] dividend,
  input  logic [sfla_pkg::SIZE_W-1:0] divisor,
  output sfla_pkg::div_result_t       result
);
  import sfla_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [SIZE_W-1:0]    rem;
  logic [ADDR_W-1:0]    quo;
  logic [SIZE_W-1:0]    dsr;
  logic [SIZE_W:0]      trial;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem, quo[ADDR_W-1]} - {1'b0, dsr};

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_CNT_W'(DIV_STEPS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - DIV_CNT_W'(1);
      done <= (cnt == DIV_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Shift one quotient bit in per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (cnt != '0) begin
      if (!trial[SIZE_W]) begin
        rem <= trial[SIZE_W-1:0];
        quo <= {quo[ADDR_W-2:0], 1'b1};
      end else begin
        rem <= {rem[SIZE_W-2:0], quo[ADDR_W-1]};
        quo <= {quo[ADDR_W-2:0], 1'b0};
      end
    end
  end

  assign result.done     = done;
  assign result.rem_zero = (rem == '0);
  assign result.quotient = quo;

endmodule

// ===== design/sfla_store.sv =====
// Slab state memories: next-link and free bit tables sharing one write address
// and one read address; read data is registered. Depends on sfla_pkg.
module sfla_store #(
  parameter int AW    = 10,
  parameter int IW    = 11,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          link_we,
  input  logic          free_we,
  input  logic [AW-1:0] wr_addr,
  input  logic [IW-1:0] link_wdata,
  input  logic          free_wdata,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [IW-1:0] link_q,
  output logic          free_q
);
  import sfla_pkg::*;

  logic [IW-1:0] link_mem [DEPTH];
  logic          free_mem [DEPTH];

  // Write ports
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    if (free_we) begin
      free_mem[wr_addr] <= free_wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      link_q <= link_mem[rd_addr];
      free_q <= free_mem[rd_addr];
    end
  end

endmodule

// ===== design/slab_free_list_allocator.sv =====
// Slab free list allocator, one response per request, one request at a time.
// Allocate goes through ST_ALLOC_CHK to ST_DONE (directly on an empty list or a
// stale head); free through ST_FREE_RANGE and, if in range, the iterative
// divider in ST_FREE_DIV, then ST_FREE_CHK; initialise sweeps every slab in
// ST_INIT, one memory write per slab; no-op goes straight to ST_DONE. Reset is
// sync; a clearing pass then sets every free bit while requests stall.
module slab_free_list_allocator #(
  parameter int MAX_SLABS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sfla_pkg::in_req_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sfla_pkg::out_rsp_t    out_data,
  input  logic                  cfg_write,
  input  sfla_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]           cfg_data
);
  import sfla_pkg::*;

  localparam int AW = $clog2(MAX_SLABS);
  localparam int IW = $clog2(MAX_SLABS + 1);
  localparam int CW = (IW > COUNT_W) ? IW : COUNT_W;
  localparam int PW = CW + SIZE_W;
  localparam int LW = (PW > ADDR_W + 1) ? PW : ADDR_W + 1;
  localparam logic [IW-1:0] NULL_LINK = IW'(MAX_SLABS);

  // Configuration registers
  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  slab_bytes;
  logic [COUNT_W-1:0] slab_count;
  logic               check_enable;

  // Control and data registers
  state_t            state, state_next;
  logic [IW-1:0]     head;
  logic [IW-1:0]     sweep;
  logic [ADDR_W-1:0] offset;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     idx;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;

  // Combinational controls
  logic              in_accept;
  logic              res_load;
  logic [ADDR_W-1:0] res_addr_d;
  status_t           res_status_d;
  logic              head_load;
  logic [IW-1:0]     head_d;
  logic              idx_load;
  logic              out_load;
  logic              div_start;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              link_we;
  logic              free_we;
  logic [AW-1:0]     wr_addr;
  logic [IW-1:0]     link_wdata;
  logic              free_wdata;
  logic [IW-1:0]     link_q;
  logic              free_q;
  div_result_t       div;

  logic [SIZE_W-1:0] size;
  logic [CW-1:0]     count;
  logic [CW-1:0]     mul_a;
  logic [LW-1:0]     prod_ext;
  logic [LW-1:0]     offset_ext;
  logic              sweep_last;

  // Effective slab size and count
  always_comb begin
    if (slab_bytes < SIZE_MIN) begin
      size = SIZE_MIN;
    end else if (slab_bytes > SIZE_MAX) begin
      size = SIZE_MAX;
    end else begin
      size = slab_bytes;
    end
  end

  assign count = (CW'(slab_count) > CW'(MAX_SLABS)) ? CW'(MAX_SLABS) : CW'(slab_count);

  assign in_accept  = in_valid && !in_stall;
  assign mul_a      = (in_data.op == OP_ALLOC) ? CW'(head) : count;
  assign prod_ext   = LW'(prod);
  assign offset_ext = LW'(offset);
  assign sweep_last = (sweep == IW'(MAX_SLABS - 1));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      slab_bytes   <= 17'd16;
      slab_count   <= 11'd1024;
      check_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        CFG_SLAB_BYTES:   slab_bytes   <= cfg_data[SIZE_W-1:0];
        CFG_SLAB_COUNT:   slab_count   <= cfg_data[COUNT_W-1:0];
        CFG_CHECK_ENABLE: check_enable <= cfg_data[0];
      endcase
    end
  end

  // State register and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      head      <= NULL_LINK;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (head_load) begin
        head <= head_d;
      end
      sweep <= (state == ST_INIT || state == ST_CLEAR) ? sweep + IW'(1) : '0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      offset <= in_data.free_address - base_address;
      prod   <= PW'(mul_a) * PW'(size);
    end
    if (idx_load) begin
      idx <= div.quotient[AW-1:0];
    end
    if (res_load) begin
      res_addr   <= res_addr_d;
      res_status <= res_status_d;
    end
    if (out_load) begin
      out_data.slab_address <= res_addr;
      out_data.status       <= res_status;
    end
  end

  // Next state and controls
  always_comb begin
    state_next   = state;
    in_stall     = (state != ST_IDLE);
    res_load     = 1'b0;
    res_addr_d   = '0;
    res_status_d = STATUS_OK;
    head_load    = 1'b0;
    head_d       = head;
    idx_load     = 1'b0;
    out_load     = 1'b0;
    div_start    = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = head[AW-1:0];
    link_we      = 1'b0;
    free_we      = 1'b0;
    wr_addr      = sweep[AW-1:0];
    link_wdata   = head;
    free_wdata   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        free_we = 1'b1;
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          res_load = 1'b1;
          unique case (in_data.op)
            OP_ALLOC: begin
              if (head == NULL_LINK) begin
                res_status_d = STATUS_OUT_OF_MEM;
                state_next   = ST_DONE;
              end else if (CW'(head) >= count) begin
                res_status_d = STATUS_CORRUPT;
                state_next   = ST_DONE;
              end else begin
                rd_en      = 1'b1;
                state_next = ST_ALLOC_CHK;
              end
            end
            OP_FREE: state_next = ST_FREE_RANGE;
            OP_INIT: state_next = ST_INIT;
            OP_NOP:  state_next = ST_DONE;
          endcase
        end
      end
      ST_ALLOC_CHK: begin
        res_load   = 1'b1;
        state_next = ST_DONE;
        if (check_enable && !free_q) begin
          res_status_d = STATUS_CORRUPT;
        end else begin
          free_we    = check_enable;
          free_wdata = 1'b0;
          wr_addr    = head[AW-1:0];
          head_load  = 1'b1;
          head_d     = link_q;
          res_addr_d = base_address + prod_ext[ADDR_W-1:0];
        end
      end
      ST_FREE_RANGE: begin
        if (offset_ext >= prod_ext) begin
          res_load     = 1'b1;
          res_status_d = STATUS_RANGE;
          state_next   = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_FREE_DIV;
        end
      end
      ST_FREE_DIV: begin
        if (div.done) begin
          if (!div.rem_zero) begin
            res_load     = 1'b1;
            res_status_d = STATUS_MISALIGN;
            state_next   = ST_DONE;
          end else if (div.quotient >= ADDR_W'(MAX_SLABS)) begin
            res_load     = 1'b1;
            res_status_d = STATUS_RANGE;
            state_next   = ST_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = div.quotient[AW-1:0];
            idx_load   = 1'b1;
            state_next = ST_FREE_CHK;
          end
        end
      end
      ST_FREE_CHK: begin
        res_load   = 1'b1;
        state_next = ST_DONE;
        if (check_enable && free_q) begin
          res_status_d = STATUS_DOUBLE;
        end else begin
          link_we    = 1'b1;
          wr_addr    = idx;
          link_wdata = head;
          free_we    = check_enable;
          free_wdata = 1'b1;
          head_load  = 1'b1;
          head_d     = IW'(idx);
        end
      end
      ST_INIT: begin
        // Chain slab i to i+1, last to null; mark every slab free
        link_we    = (CW'(sweep) < count);
        link_wdata = (CW'(sweep) + CW'(1) < count) ? sweep + IW'(1) : NULL_LINK;
        free_we    = 1'b1;
        if (sweep_last) begin
          head_load  = 1'b1;
          head_d     = (count != '0) ? '0 : NULL_LINK;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  sfla_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset),
    .divisor  (size),
    .result   (div)
  );

  sfla_store #(
    .AW    (AW),
    .IW    (IW),
    .DEPTH (MAX_SLABS)
  ) u_store (
    .clk        (clk),
    .link_we    (link_we),
    .free_we    (free_we),
    .wr_addr    (wr_addr),
    .link_wdata (link_wdata),
    .free_wdata (free_wdata),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .link_q     (link_q),
    .free_q     (free_q)
  );

`ifndef SYNTHESIS
  // Reset always starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> state == ST_CLEAR)
    else $error("clearing pass not started after reset");

  // An accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != ST_IDLE)
    else $error("request accepted without leaving idle");

  // Link table is written only by init or a successful free
  a_link_write: assert property (@(posedge clk) disable iff (rst)
    link_we |-> (state == ST_INIT || state == ST_FREE_CHK))
    else $error("link write outside init or free");

  // A finished request with an empty output register shows its response next
  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_valid) |=> out_valid && state == ST_IDLE)
    else $error("finished response not presented");
`endif

endmodule
